[src/mmjd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mmjd_pkg
// Shared types, character codes and the header-end tracker for the multipart
// deframer.
// ----------------------------------------------------------------------------
package mmjd_pkg;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_DASH = 8'h2D;

	// Configuration register indexes.
	localparam logic [1:0] REG_BOUNDARY_LOW  = 2'd0;
	localparam logic [1:0] REG_BOUNDARY_HIGH = 2'd1;
	localparam logic [1:0] REG_BOUNDARY_LEN  = 2'd2;

	// Output queue geometry.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	typedef enum logic [2:0] {
		PH_SEEK,
		PH_AFTER_MARK,
		PH_AFTER_CR,
		PH_HEADERS,
		PH_PAYLOAD
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} res_item_t;

	// Up to three result beats per input beat, item 0 leaves first.
	typedef struct packed {
		logic [1:0]          num;
		res_item_t [2:0]     item;
	} res_bundle_t;

	typedef struct packed {
		logic       to_payload;
		logic [1:0] progress;
	} hdr_step_t;

	// Tracks CR LF CR LF at the end of the part headers.
	function automatic hdr_step_t hdr_step(input logic [1:0] progress, input logic [7:0] b);
		hdr_step_t r;
		r.to_payload = 1'b0;
		r.progress   = 2'd0;
		if (b == CH_LF) begin
			if (progress == 2'd3) begin
				r.to_payload = 1'b1;
			end else if (progress == 2'd1) begin
				r.progress = 2'd2;
			end
		end else if (b == CH_CR) begin
			r.progress = (progress == 2'd2) ? 2'd3 : 2'd1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[src/multipart_mjpeg_deframer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multipart_mjpeg_deframer
// Splits a multipart HTTP body into part payloads, one byte per beat.
// ----------------------------------------------------------------------------
// Input stream s_axis: one body byte per beat; tuser high on a beat clears the
// parser and the byte is dropped. Output stream m_axis: payload bytes of each
// part, tlast on the final byte of a part. Parts with no payload give no beats.
// Configuration: cfg_index 0 and 1 write the low and high boundary bytes,
// 2 writes the boundary length and also clears the parser. Write only while
// the block is idle; cfg_ready is always high.
// Throughput: one input beat per cycle while s_axis_tready is high. Each beat
// is handled by the history compare; a released payload byte goes through the
// output queue to m_axis. The hold-back window keeps marker length plus two
// bytes inside the block until a marker decides their fate.
// A completed marker can release three beats at once into a four-entry queue;
// s_axis_tready drops while the queue holds more than one beat, so a stalled
// receiver backs up into the input after at most a few beats.
// Reset: boundary all zero, length one, parser seeking the first marker,
// queue empty.
// ----------------------------------------------------------------------------
module multipart_mjpeg_deframer #(
	parameter int MAX_BOUNDARY = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  wire logic        s_axis_tuser,   // [0] restart
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [7:0] payload_byte
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	import mmjd_pkg::*;

	localparam int MD = MAX_BOUNDARY + 2;
	localparam int CW = $clog2(MAX_BOUNDARY + 6);

	logic [MD-1:0][7:0] mark;
	logic [MD-1:0]      mark_mask;
	logic [CW-1:0]      mlen;
	logic               cfg_clear;
	logic               beat;
	res_bundle_t        res;

	assign cfg_ready = 1'b1;
	assign beat      = s_axis_tvalid && s_axis_tready;

	mmjd_cfg #(.MAX_BOUNDARY(MAX_BOUNDARY)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cfg_valid && cfg_ready),
		.wr_index  (cfg_index),
		.wr_data   (cfg_data),
		.mark      (mark),
		.mark_mask (mark_mask),
		.mlen      (mlen),
		.clear     (cfg_clear)
	);

	mmjd_parser #(.MAX_BOUNDARY(MAX_BOUNDARY)) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.in_byte   (s_axis_tdata),
		.restart   (s_axis_tuser),
		.cfg_clear (cfg_clear),
		.mark      (mark),
		.mark_mask (mark_mask),
		.mlen      (mlen),
		.res       (res)
	);

	mmjd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res),
		.space     (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
`default_nettype wire

[src/mmjd_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mmjd_cfg
// Boundary registers. Keeps the marker ("--" plus boundary) right-aligned
// against the byte history, with a mask of the positions in use.
// ----------------------------------------------------------------------------
module mmjd_cfg #(
	parameter int MAX_BOUNDARY = 16,
	localparam int MD = MAX_BOUNDARY + 2,
	localparam int CW = $clog2(MAX_BOUNDARY + 6)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [1:0]           wr_index,
	input  wire logic [63:0]          wr_data,
	output logic      [MD-1:0][7:0]   mark,
	output logic      [MD-1:0]        mark_mask,
	output logic      [CW-1:0]        mlen,
	output logic                      clear
);
	import mmjd_pkg::*;

	logic [63:0]        low_q, high_q, low_d, high_d;
	logic [4:0]         len_q, len_d, elen;
	logic [MD-1:0][7:0] mark_q, mark_d;
	logic [MD-1:0]      mask_q, mask_d;
	logic [CW-1:0]      mlen_q, mlen_d;
	logic [15:0][7:0]   bnd;

	assign clear = wr_en && (wr_index == REG_BOUNDARY_LEN);

	always_comb begin
		int pos;
		low_d  = (wr_en && wr_index == REG_BOUNDARY_LOW)  ? wr_data : low_q;
		high_d = (wr_en && wr_index == REG_BOUNDARY_HIGH) ? wr_data : high_q;
		len_d  = clear ? wr_data[4:0] : len_q;
		if (len_d == 5'd0) begin
			elen = 5'd1;
		end else if (len_d > 5'(MAX_BOUNDARY)) begin
			elen = 5'(MAX_BOUNDARY);
		end else begin
			elen = len_d;
		end
		mlen_d = CW'(elen) + CW'(2);
		bnd    = {high_d, low_d};
		for (int j = 0; j < MD; j++) begin
			pos       = int'(mlen_d) - 1 - j;
			mask_d[j] = (j < int'(mlen_d));
			if (pos < 2) begin
				mark_d[j] = CH_DASH;
			end else begin
				mark_d[j] = bnd[4'(pos - 2)];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
			len_q  <= 5'd1;
			mlen_q <= CW'(3);
			for (int j = 0; j < MD; j++) begin
				mark_q[j] <= (j == 1 || j == 2) ? CH_DASH : 8'h00;
				mask_q[j] <= (j < 3);
			end
		end else if (wr_en) begin
			low_q  <= low_d;
			high_q <= high_d;
			len_q  <= len_d;
			mlen_q <= mlen_d;
			mark_q <= mark_d;
			mask_q <= mask_d;
		end
	end

	assign mark      = mark_q;
	assign mark_mask = mask_q;
	assign mlen      = mlen_q;

endmodule
`default_nettype wire

[src/mmjd_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mmjd_parser
// Byte history, parse phase and hold-back counter. Every accepted beat is
// handled by combinational logic and produces up to three result beats.
// ----------------------------------------------------------------------------
module mmjd_parser #(
	parameter int MAX_BOUNDARY = 16,
	localparam int MD = MAX_BOUNDARY + 2,
	localparam int HD = MAX_BOUNDARY + 5,
	localparam int HW = $clog2(HD),
	localparam int CW = $clog2(MAX_BOUNDARY + 6)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    beat,
	input  wire logic [7:0]              in_byte,
	input  wire logic                    restart,
	input  wire logic                    cfg_clear,
	input  wire logic [MD-1:0][7:0]      mark,
	input  wire logic [MD-1:0]           mark_mask,
	input  wire logic [CW-1:0]           mlen,
	output mmjd_pkg::res_bundle_t        res
);
	import mmjd_pkg::*;

	phase_t             phase_q, phase_d;
	logic [HD-1:0][7:0] hist_q, hnew;
	logic [1:0]         hep_q, hep_d;
	logic [CW-1:0]      cnt_q, cnt_d, cnt_inc, diff;
	logic [MD-1:0]      eq;
	logic               hit, skip2;
	logic [1:0]         n;
	logic [7:0]         t0, t1, t2;
	hdr_step_t          hs, hs0;
	res_bundle_t        res_d;

	always_comb begin
		hnew[0] = in_byte;
		for (int j = 1; j < HD; j++) begin
			hnew[j] = hist_q[j-1];
		end
		for (int j = 0; j < MD; j++) begin
			eq[j] = !mark_mask[j] || (hnew[j] == mark[j]);
		end
		hit = &eq;

		cnt_inc = (cnt_q < CW'(HD)) ? cnt_q + CW'(1) : cnt_q;
		diff    = cnt_inc - mlen;
		n       = (diff > CW'(3)) ? 2'd3 : diff[1:0];
		t0      = hnew[HW'(mlen)];
		t1      = hnew[HW'(mlen + CW'(1))];
		t2      = hnew[HW'(mlen + CW'(2))];
		skip2   = (n >= 2'd2) && (t0 == CH_LF) && (t1 == CH_CR);
		hs      = hdr_step(hep_q, in_byte);
		hs0     = hdr_step(2'd0, in_byte);

		phase_d = phase_q;
		hep_d   = hep_q;
		cnt_d   = cnt_q;
		res_d   = '0;

		case (phase_q)
			PH_SEEK: begin
				if (hit) begin
					phase_d = PH_AFTER_MARK;
				end
			end
			PH_AFTER_MARK: begin
				hep_d = 2'd0;
				if (in_byte == CH_CR) begin
					phase_d = PH_AFTER_CR;
				end else begin
					phase_d = PH_HEADERS;
					if (in_byte != CH_LF) begin
						hep_d = hs0.progress;
					end
				end
			end
			PH_AFTER_CR: begin
				phase_d = PH_HEADERS;
				hep_d   = 2'd0;
				if (in_byte != CH_LF) begin
					hep_d = hs0.progress;
				end
			end
			PH_HEADERS: begin
				hep_d = hs.progress;
				if (hs.to_payload) begin
					phase_d = PH_PAYLOAD;
					cnt_d   = '0;
				end
			end
			PH_PAYLOAD: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= mlen && hit) begin
					// Marker complete: flush the held-back tail, less a CRLF.
					phase_d = PH_AFTER_MARK;
					cnt_d   = '0;
					hep_d   = 2'd0;
					case (n)
						2'd3: begin
							if (skip2) begin
								res_d.num     = 2'd1;
								res_d.item[0] = '{data: t2, last: 1'b1};
							end else begin
								res_d.num     = 2'd3;
								res_d.item[0] = '{data: t2, last: 1'b0};
								res_d.item[1] = '{data: t1, last: 1'b0};
								res_d.item[2] = '{data: t0, last: 1'b1};
							end
						end
						2'd2: begin
							if (!skip2) begin
								res_d.num     = 2'd2;
								res_d.item[0] = '{data: t1, last: 1'b0};
								res_d.item[1] = '{data: t0, last: 1'b1};
							end
						end
						2'd1: begin
							res_d.num     = 2'd1;
							res_d.item[0] = '{data: t0, last: 1'b1};
						end
						default: begin
							res_d.num = 2'd0;
						end
					endcase
				end else if (cnt_inc > mlen + CW'(2)) begin
					res_d.num     = 2'd1;
					res_d.item[0] = '{data: hnew[HW'(cnt_inc - CW'(1))], last: 1'b0};
					cnt_d         = cnt_inc - CW'(1);
				end
			end
			default: begin
				phase_d = PH_SEEK;
				hep_d   = 2'd0;
				cnt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			hist_q  <= '0;
			hep_q   <= 2'd0;
			cnt_q   <= '0;
		end else if (cfg_clear || (beat && restart)) begin
			phase_q <= PH_SEEK;
			hist_q  <= '0;
			hep_q   <= 2'd0;
			cnt_q   <= '0;
		end else if (beat) begin
			phase_q <= (phase_q > PH_PAYLOAD) ? PH_SEEK : phase_d;
			hist_q  <= (phase_q > PH_PAYLOAD) ? '0 : hnew;
			hep_q   <= hep_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		res = res_d;
		if (!beat || restart || cfg_clear) begin
			res.num = 2'd0;
		end
	end

endmodule
`default_nettype wire

[src/mmjd_outq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mmjd_outq
// Four-entry result queue. Takes up to three beats per cycle and presents
// one registered beat per cycle on the output stream while out_ready is high.
// ----------------------------------------------------------------------------
module mmjd_outq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mmjd_pkg::res_bundle_t push,
	output logic                       space,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 out_data,
	output logic                       out_last
);
	import mmjd_pkg::*;

	res_item_t         mem [Q_DEPTH];
	logic [Q_AW-1:0]   head_q, tail_q;
	logic [Q_CW-1:0]   count_q;
	logic              pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_data  = mem[head_q].data;
	assign out_last  = mem[head_q].last;
	// Room for a full three-beat burst.
	assign space     = (count_q <= Q_CW'(Q_DEPTH - 3));

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (i < int'(push.num)) begin
				mem[tail_q + Q_AW'(i)] <= push.item[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + Q_AW'(push.num);
			head_q  <= head_q + Q_AW'(pop);
			count_q <= count_q + Q_CW'(push.num) - Q_CW'(pop);
		end
	end

endmodule
`default_nettype wire
